/* hdl/icds_pkg.sv */
package icds_pkg;

    // Field widths fixed by the interface.
    localparam int TARGET_W = 31;
    localparam int SRC_W    = 32;
    localparam int M_W      = 4;
    localparam int N_W      = 3;
    localparam int WORD_W   = M_W + N_W;

    // The source clock is multiplied by a reciprocal one half at a time.
    localparam int HALF_W      = SRC_W / 2;
    // Reciprocals are scaled by 2^40, which keeps the quotient exact for any
    // divisor up to 256 and a 32-bit clock; ceil(2^40 / 10) needs 37 bits.
    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_W     = 37;
    localparam int ACC_W       = SRC_W + RECIP_W;

    // The smallest divisor is 10, so a quotient of a 32-bit clock fits in 29 bits.
    localparam int FREQ_W   = ACC_W - RECIP_SHIFT;

    localparam int unsigned BASE_DIVISOR = 10;
    localparam logic [M_W-1:0] FALLBACK_M = 4'd5;
    localparam logic [N_W-1:0] FALLBACK_N = 3'd0;
    localparam logic [SRC_W-1:0] SRC_RESET = 32'd24000000;

    // Control broadcast from the divider sequencer to every cell.
    typedef struct packed {
        logic              load;
        logic              step;
        logic [HALF_W-1:0] src_half;
    } div_ctrl_t;

    // Best candidate so far, handed from cell to cell.
    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic                found;
        logic [FREQ_W-1:0]   freq;
        logic [M_W-1:0]      m;
        logic [N_W-1:0]      n;
    } cand_t;

endpackage

/* hdl/icds_cell.sv */
module icds_cell import icds_pkg::*; #(
    parameter int M_INDEX = 0,
    parameter int N_COUNT = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  div_ctrl_t div_ctrl,
    input  logic      valid_in,
    input  cand_t     cand_in,
    output logic      valid_out,
    output cand_t     cand_out
);

    localparam logic [63:0] DIVISOR = 64'(BASE_DIVISOR * (M_INDEX + 1));
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + DIVISOR - 64'd1) / DIVISOR);

    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [HALF_W+RECIP_W-1:0] partial;
    logic [FREQ_W-1:0]         quot;
    logic                      valid_reg;
    cand_t                     cand_reg, cand_next;

    logic              pick_ok;
    logic [FREQ_W-1:0] pick_freq;
    logic [N_W-1:0]    pick_n;
    logic              better;

    // Quotient of the source clock by this cell's divisor: the clock is
    // multiplied by a scaled reciprocal, low half on load and high half on
    // step, and the top bits of the product are the quotient.
    always_comb
    begin
        partial  = div_ctrl.src_half * RECIP;
        acc_next = acc_reg;
        if (div_ctrl.load)
        begin
            acc_next = {{(ACC_W-HALF_W-RECIP_W){1'b0}}, partial};
        end
        else if (div_ctrl.step)
        begin
            acc_next = acc_reg + {partial, {HALF_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign quot = acc_reg[ACC_W-1 -: FREQ_W];

    // Rates fall as n grows, so the first n that does not exceed the target
    // has the smallest shortfall for this m.
    always_comb
    begin
        pick_ok   = 1'b0;
        pick_freq = '0;
        pick_n    = '0;
        for (int i = N_COUNT - 1; i >= 0; i--)
        begin
            if ({{(TARGET_W-FREQ_W){1'b0}}, quot >> i} <= cand_in.target)
            begin
                pick_ok   = 1'b1;
                pick_freq = quot >> i;
                pick_n    = N_W'(i);
            end
        end
    end

    // A higher rate means a smaller shortfall; on a tie the lower n comes first.
    always_comb
    begin
        better = pick_ok && (!cand_in.found || (pick_freq > cand_in.freq) ||
                 ((pick_freq == cand_in.freq) && (pick_n < cand_in.n)));
        cand_next = cand_in;
        if (better)
        begin
            cand_next.found = 1'b1;
            cand_next.freq  = pick_freq;
            cand_next.m     = M_W'(M_INDEX);
            cand_next.n     = pick_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cand_reg <= cand_next;
        end
    end

    assign valid_out = valid_reg;
    assign cand_out  = cand_reg;

endmodule

/* hdl/i2c_clock_divider_search.sv */
// An accepted target passes through the cells of the chain in order, then the output register.
// Throughput: one target per cycle while target_stall is low, one cell of the chain per m value.
// Reset: an asynchronous reset loads the source clock with 24 MHz and starts
// a divider pass of a load step and then a step; every source clock write starts the same pass.
// The cells form their quotients by a reciprocal multiplication in two
// halves, and target_stall is high during the pass.
module i2c_clock_divider_search import icds_pkg::*; #(
    parameter int M_COUNT = 16,
    parameter int N_COUNT = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SRC_W-1:0]    source_clock_hz,
    input  logic                target_valid,
    output logic                target_stall,
    input  logic [TARGET_W-1:0] target_rate_hz,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [M_W-1:0]      divide_m,
    output logic [N_W-1:0]      divide_n,
    output logic [WORD_W-1:0]   clock_control_word,
    output logic                found,
    output logic [TARGET_W-1:0] rate_shortfall
);

    logic [SRC_W-1:0]    src_reg;
    logic                load_reg;
    logic                busy_reg;
    div_ctrl_t           div_ctrl;
    logic                en;

    cand_t               chain [M_COUNT+1];
    logic [M_COUNT:0]    chain_valid;

    logic                result_valid_reg;
    logic [M_W-1:0]      m_reg;
    logic [N_W-1:0]      n_reg;
    logic                found_reg;
    logic [TARGET_W-1:0] shortfall_reg;

    assign cfg_ready = 1'b1;

    // Source clock register and the divider pass sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg  <= SRC_RESET;
            load_reg <= 1'b1;
            busy_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            src_reg  <= source_clock_hz;
            load_reg <= 1'b1;
            busy_reg <= 1'b0;
        end
        else
        begin
            load_reg <= 1'b0;
            busy_reg <= load_reg;
        end
    end

    // The low half of the source clock goes out on the load cycle and the
    // high half on the step cycle.
    assign div_ctrl.load     = load_reg;
    assign div_ctrl.step     = busy_reg;
    assign div_ctrl.src_half = load_reg ? src_reg[HALF_W-1:0] : src_reg[SRC_W-1:HALF_W];

    // The whole chain moves unless a finished result is held back.
    assign en           = !(result_valid_reg && result_stall);
    assign target_stall = load_reg || busy_reg || !en;

    assign chain_valid[0]  = target_valid && !target_stall;
    assign chain[0].target = target_rate_hz;
    assign chain[0].found  = 1'b0;
    assign chain[0].freq   = '0;
    assign chain[0].m      = '0;
    assign chain[0].n      = '0;

    for (genvar g = 0; g < M_COUNT; g++)
    begin : g_cell
        icds_cell #(
            .M_INDEX (g),
            .N_COUNT (N_COUNT)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .div_ctrl  (div_ctrl),
            .valid_in  (chain_valid[g]),
            .cand_in   (chain[g]),
            .valid_out (chain_valid[g+1]),
            .cand_out  (chain[g+1])
        );
    end

    // Output register: fallback pair when nothing qualified.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= chain_valid[M_COUNT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            found_reg <= chain[M_COUNT].found;
            if (chain[M_COUNT].found)
            begin
                m_reg         <= chain[M_COUNT].m;
                n_reg         <= chain[M_COUNT].n;
                shortfall_reg <= chain[M_COUNT].target -
                                 {{(TARGET_W-FREQ_W){1'b0}}, chain[M_COUNT].freq};
            end
            else
            begin
                m_reg         <= FALLBACK_M;
                n_reg         <= FALLBACK_N;
                shortfall_reg <= '0;
            end
        end
    end

    assign result_valid       = result_valid_reg;
    assign divide_m           = m_reg;
    assign divide_n           = n_reg;
    assign clock_control_word = {m_reg, n_reg};
    assign found              = found_reg;
    assign rate_shortfall     = shortfall_reg;

endmodule

/* hdl/icds_checker.sv */
module icds_sva import icds_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [SRC_W-1:0]    source_clock_hz,
    input logic                target_valid,
    input logic                target_stall,
    input logic [TARGET_W-1:0] target_rate_hz,
    input logic                result_valid,
    input logic                result_stall,
    input logic [M_W-1:0]      divide_m,
    input logic [N_W-1:0]      divide_n,
    input logic [WORD_W-1:0]   clock_control_word,
    input logic                found,
    input logic [TARGET_W-1:0] rate_shortfall
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(rate_shortfall) &&
        $stable(clock_control_word) && $stable(found))
    else $error("stalled result changed");

    // The control word packs the reported pair.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> clock_control_word == {divide_m, divide_n})
    else $error("control word does not match m and n");

    // Without a qualifying pair the fallback is reported with no shortfall.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |->
        divide_m == FALLBACK_M && divide_n == FALLBACK_N && rate_shortfall == '0)
    else $error("fallback result is wrong");

    // A source clock write blocks targets until the divider pass is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> target_stall)
    else $error("target accepted right after a source clock write");

endmodule

bind i2c_clock_divider_search icds_sva u_icds_checker (.*);

/* tb/sv/icds_checker.sv */
module icds_checker import icds_pkg::*; #(
    parameter int M_COUNT = 16,
    parameter int N_COUNT = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [SRC_W-1:0]    source_clock_hz,
    input  logic                target_valid,
    input  logic                target_stall,
    input  logic [TARGET_W-1:0] target_rate_hz,
    input  logic                result_valid,
    input  logic                result_stall,
    input  logic [M_W-1:0]      divide_m,
    input  logic [N_W-1:0]      divide_n,
    input  logic [WORD_W-1:0]   clock_control_word,
    input  logic                found,
    input  logic [TARGET_W-1:0] rate_shortfall,
    output int                  fail_count,
    output int                  pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [M_W-1:0]      m;
        logic [N_W-1:0]      n;
        logic [WORD_W-1:0]   word;
        logic                found;
        logic [TARGET_W-1:0] shortfall;
    } divider_choice_t;

    logic [SRC_W-1:0] source_copy;
    divider_choice_t  choice_q[$];
    int               errors_seen = 0;
    int               reports     = 0;

    assign fail_count = errors_seen;

    // Scan every (m, n) pair, n outer and m inner, and keep the closest rate
    // that does not exceed the target. A strict compare keeps the first tie.
    function automatic divider_choice_t choose_divider(logic [SRC_W-1:0] src,
                                                       logic [TARGET_W-1:0] target);
        longint unsigned divisor;
        longint unsigned freq;
        longint unsigned best;
        bit              have;
        divider_choice_t r;
        have = 1'b0;
        best = 0;
        r.m  = FALLBACK_M;
        r.n  = FALLBACK_N;
        for (int n = 0; n < N_COUNT; n++)
        begin
            for (int m = 0; m < M_COUNT; m++)
            begin
                divisor = longint'(BASE_DIVISOR) * longint'(m + 1) * (64'd1 << n);
                freq    = longint'(src) / divisor;
                if (freq <= longint'(target) && (!have || (target - freq) < best))
                begin
                    have = 1'b1;
                    best = target - freq;
                    r.m  = M_W'(m);
                    r.n  = N_W'(n);
                end
            end
        end
        r.word      = {r.m, r.n};
        r.found     = have;
        r.shortfall = have ? TARGET_W'(best) : '0;
        return r;
    endfunction

    // Track the source clock, predict each accepted target and compare each
    // accepted result with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        divider_choice_t got;
        divider_choice_t want;
        if (!rst_n)
        begin
            source_copy <= SRC_RESET;
            choice_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                source_copy <= source_clock_hz;
            if (target_valid && !target_stall)
                choice_q.push_back(choose_divider(source_copy, target_rate_hz));
            if (result_valid && !result_stall)
            begin
                got = '{divide_m, divide_n, clock_control_word, found, rate_shortfall};
                if (choice_q.size() == 0)
                begin
                    errors_seen++;
                    if (reports < 10)
                    begin
                        reports++;
                        $display("%0t: result transaction with nothing expected: m=%0d n=%0d",
                                 $realtime, divide_m, divide_n);
                    end
                end
                else
                begin
                    want = choice_q.pop_front();
                    if (got !== want)
                    begin
                        errors_seen++;
                        if (reports < 10)
                        begin
                            reports++;
                            $display("%0t: mismatch expected m=%0d n=%0d word=%0h found=%0b short=%0d",
                                     $realtime, want.m, want.n, want.word, want.found,
                                     want.shortfall);
                            $display("%0t:            actual m=%0d n=%0d word=%0h found=%0b short=%0d",
                                     $realtime, got.m, got.n, got.word, got.found,
                                     got.shortfall);
                        end
                    end
                end
            end
            pending <= choice_q.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import icds_pkg::*;

    localparam int M_COUNT = 16;
    localparam int N_COUNT = 8;
    localparam int LATENCY = M_COUNT + 1;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [SRC_W-1:0]    source_clock_hz;
    logic                target_valid;
    logic                target_stall;
    logic [TARGET_W-1:0] target_rate_hz;
    logic                result_valid;
    logic                result_stall;
    logic [M_W-1:0]      divide_m;
    logic [N_W-1:0]      divide_n;
    logic [WORD_W-1:0]   clock_control_word;
    logic                found;
    logic [TARGET_W-1:0] rate_shortfall;

    int                  fail_count;
    int                  pending;
    logic [SRC_W-1:0]    cur_source;
    bit                  random_phase;
    bit                  quiet;
    bit                  long_hold_done;

    i2c_clock_divider_search #(
        .M_COUNT (M_COUNT),
        .N_COUNT (N_COUNT)
    ) u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .source_clock_hz    (source_clock_hz),
        .target_valid       (target_valid),
        .target_stall       (target_stall),
        .target_rate_hz     (target_rate_hz),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .divide_m           (divide_m),
        .divide_n           (divide_n),
        .clock_control_word (clock_control_word),
        .found              (found),
        .rate_shortfall     (rate_shortfall)
    );

    icds_checker #(
        .M_COUNT (M_COUNT),
        .N_COUNT (N_COUNT)
    ) u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .source_clock_hz    (source_clock_hz),
        .target_valid       (target_valid),
        .target_stall       (target_stall),
        .target_rate_hz     (target_rate_hz),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .divide_m           (divide_m),
        .divide_n           (divide_n),
        .clock_control_word (clock_control_word),
        .found              (found),
        .rate_shortfall     (rate_shortfall),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung handshake.
    initial
    begin
        #3ms;
        $display("tb_top: errors");
        $finish;
    end

    // Write the source clock register and wait for the transaction.
    task automatic write_source(logic [SRC_W-1:0] value);
        cfg_valid       <= 1'b1;
        source_clock_hz <= value;
        cur_source       = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one target and hold it until the block takes it.
    task automatic send_target(logic [TARGET_W-1:0] value);
        target_valid   <= 1'b1;
        target_rate_hz <= value;
        @(posedge clk);
        while (target_stall)
            @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic wait_drained();
        target_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // A target close to the rate of a random divider pair, to land on exact
    // matches and near misses.
    function automatic logic [TARGET_W-1:0] near_rate(logic [SRC_W-1:0] src);
        longint unsigned f;
        int              m;
        int              n;
        int              d;
        m = $urandom_range(0, M_COUNT - 1);
        n = $urandom_range(0, N_COUNT - 1);
        d = $urandom_range(0, 4) - 2;
        f = longint'(src) / (longint'(BASE_DIVISOR) * longint'(m + 1) * (64'd1 << n));
        if (d < 0 && f < 2)
            return '0;
        return TARGET_W'(f + d);
    endfunction

    // Random targets offered in bursts with random gaps between them.
    task automatic run_random(int count);
        int                  sent;
        int                  burst;
        int                  gap;
        logic [TARGET_W-1:0] value;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: value = near_rate(cur_source);
                    5, 6, 7:       value = TARGET_W'($urandom());
                    8:             value = TARGET_W'($urandom_range(0, 3000));
                    default:       value = $urandom_range(0, 1) ? '0 : '1;
                endcase
                send_target(value);
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                target_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Receiver stall pattern: segments of no stall, light, heavy and
    // alternating stall, plus one long hold-off once random_phase is set.
    initial
    begin
        int mode;
        int len;
        @(posedge clk);
        forever
        begin
            if (random_phase && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                result_stall <= 1'b1;
                repeat (150) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(10, 60);
                for (int i = 0; i < len; i++)
                begin
                    if (quiet)
                        result_stall <= 1'b0;
                    else
                        case (mode)
                            0:       result_stall <= 1'b0;
                            1:       result_stall <= ($urandom_range(0, 99) < 25);
                            2:       result_stall <= ($urandom_range(0, 99) < 70);
                            default: result_stall <= i[0];
                        endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        source_clock_hz = '0;
        target_valid    = 1'b0;
        target_rate_hz  = '0;
        result_stall    = 1'b0;
        random_phase    = 1'b0;
        quiet           = 1'b0;
        long_hold_done  = 1'b0;
        cur_source      = SRC_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset clock of 24 MHz: no qualifying pair, exact matches at both
        // ends of the scan, ties, and extreme targets.
        send_target(31'd0);
        send_target(31'd1);
        send_target(31'd1170);
        send_target(31'd1171);
        send_target(31'd1172);
        send_target(31'd2400000);
        send_target(31'd2399999);
        send_target(31'd2400001);
        send_target(31'd1200000);
        send_target(31'd150000);
        send_target(31'd100000);
        send_target(31'd400000);
        send_target(31'd1000000);
        send_target(31'h7fffffff);
        send_target(31'h55555555);
        send_target(31'h2aaaaaaa);
        send_target(31'h40000000);
        wait_drained();

        // Source clock zero: every rate is zero and pair (0,0) wins.
        write_source(32'd0);
        send_target(31'd0);
        send_target(31'd1);
        send_target(31'h7fffffff);
        run_random(60);
        wait_drained();

        // Largest source clock.
        write_source(32'hffffffff);
        send_target(31'd0);
        send_target(31'd209714);
        send_target(31'd209715);
        send_target(31'd429496729);
        send_target(31'h7fffffff);
        run_random(200);
        wait_drained();

        // Back to the reset value, with the long receiver hold-off.
        write_source(SRC_RESET);
        random_phase <= 1'b1;
        run_random(300);
        wait_drained();

        write_source(32'($urandom()));
        run_random(250);
        wait_drained();

        write_source(32'($urandom_range(1, 5000)));
        run_random(150);
        wait_drained();

        write_source(32'd1);
        run_random(40);
        wait_drained();

        // Let any stray result show up before the verdict.
        quiet <= 1'b1;
        repeat (2 * LATENCY + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
